// File: src/qfhp_pkg.sv
`default_nettype none
//------------------------------------------------------------------------------
// QUIC frame header parser - shared definitions
// Codes, frame type values, parse phases and the event record that passes
// from the parsing front end to the result emitter.
//------------------------------------------------------------------------------
package qfhp_pkg;

	localparam int CountBitsDef = 16;

	localparam int QDepth   = 4;
	localparam int QPtrBits = $clog2(QDepth);
	localparam int QCntBits = $clog2(QDepth + 1);

	localparam int VarintBits = 62;

	localparam logic [7:0] FtStreamLo      = 8'h08;
	localparam logic [7:0] FtStreamHi      = 8'h0F;
	localparam logic [7:0] FtMaxData       = 8'h10;
	localparam logic [7:0] FtMaxStreamData = 8'h11;

	// bit positions of the STREAM type flags (0x04, 0x02, 0x01)
	localparam int FlOff = 2;
	localparam int FlLen = 1;
	localparam int FlFin = 0;

	typedef logic [VarintBits-1:0] varint_t;

	typedef enum logic [1:0] {
		RkPayload  = 2'd0,
		RkComplete = 2'd1,
		RkError    = 2'd2
	} result_kind_t;

	typedef enum logic [1:0] {
		FkStream        = 2'd0,
		FkMaxData       = 2'd1,
		FkMaxStreamData = 2'd2
	} frame_kind_t;

	typedef enum logic [1:0] {
		ErrTrunc = 2'd0,
		ErrType  = 2'd1,
		ErrCount = 2'd2
	} err_code_t;

	typedef enum logic [3:0] {
		PhType    = 4'd0,
		PhSid     = 4'd1,
		PhOff     = 4'd2,
		PhLen     = 4'd3,
		PhPayload = 4'd4,
		PhFsid    = 4'd5,
		PhFval    = 4'd6,
		PhSkip    = 4'd7
	} phase_t;

	typedef struct packed {
		logic        pay;
		logic [7:0]  pay_byte;
		logic        close;
		logic        is_err;
		err_code_t   err_code;
		frame_kind_t kind;
		varint_t     ident;
		varint_t     value;
		logic        fin;
		varint_t     plen;
		logic [15:0] bytes;
	} event_t;

endpackage
`default_nettype wire

// File: src/qfhp_in_if.sv
`default_nettype none
//------------------------------------------------------------------------------
// QUIC frame header parser - byte channel
// Valid/ready channel carrying one buffer byte and its last-byte flag.
//------------------------------------------------------------------------------
interface qfhp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// File: src/qfhp_out_if.sv
`default_nettype none
//------------------------------------------------------------------------------
// QUIC frame header parser - result channel
// Valid/ready channel carrying one result item.
//------------------------------------------------------------------------------
interface qfhp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [7:0]  payload_byte;
	logic [1:0]  frame_kind;
	logic [61:0] stream_ident;
	logic [61:0] field_value;
	logic        fin_flag;
	logic [61:0] payload_length;
	logic [15:0] bytes_consumed;
	logic [1:0]  error_code;
	logic        run_end;

	modport source (
		output valid, input ready,
		output result_kind, output payload_byte, output frame_kind, output stream_ident,
		output field_value, output fin_flag, output payload_length, output bytes_consumed,
		output error_code, output run_end
	);
	modport sink (
		input valid, output ready,
		input result_kind, input payload_byte, input frame_kind, input stream_ident,
		input field_value, input fin_flag, input payload_length, input bytes_consumed,
		input error_code, input run_end
	);
endinterface
`default_nettype wire

// File: src/qfhp_front.sv
`default_nettype none
//------------------------------------------------------------------------------
// QUIC frame header parser - front end
// Accepts buffer bytes, decodes varints and frame fields, and turns each byte
// that carries payload or closes the frame into an event for the queue.
//------------------------------------------------------------------------------
module qfhp_front #(
	parameter int COUNT_BITS = qfhp_pkg::CountBitsDef
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	qfhp_in_if.sink              data,
	output      logic            push,
	output      qfhp_pkg::event_t ev,
	input  wire logic            full
);
	import qfhp_pkg::*;

	localparam logic [COUNT_BITS-1:0] CountMax     = '1;
	localparam logic [62:0]           CountMaxWide = 63'(CountMax);

	phase_t                phase_q;
	varint_t               accum_q;
	logic [2:0]            left_q;
	logic [2:0]            flags_q;
	frame_kind_t           kind_q;
	varint_t               ident_q;
	varint_t               value_q;
	varint_t               plen_q;
	logic [COUNT_BITS-1:0] bc_q;

	phase_t                ph_n;
	varint_t               acc_n;
	logic [2:0]            left_n;
	logic [2:0]            flags_n;
	frame_kind_t           kind_n;
	varint_t               ident_n;
	varint_t               value_n;
	varint_t               plen_n;
	logic [COUNT_BITS-1:0] bc_n;
	logic [62:0]           len_sum;

	logic      accept;
	logic      last;
	logic      ev_pay;
	logic      ev_close;
	logic      close_err;
	err_code_t err_code;

	assign data.ready = !full;
	assign accept     = data.valid && data.ready;
	assign last       = data.last_byte;
	assign len_sum    = 63'(acc_n) + 63'(bc_n);

	// byte decode
	always_comb begin
		ev_pay    = 1'b0;
		ev_close  = 1'b0;
		close_err = 1'b0;
		err_code  = ErrTrunc;
		ph_n      = phase_q;
		acc_n     = accum_q;
		left_n    = left_q;
		flags_n   = flags_q;
		kind_n    = kind_q;
		ident_n   = ident_q;
		value_n   = value_q;
		plen_n    = plen_q;
		bc_n      = bc_q;
		if (phase_q != PhSkip) begin
			if (bc_q == CountMax) begin
				ev_close  = 1'b1;
				close_err = 1'b1;
				err_code  = ErrCount;
			end else begin
				bc_n = bc_q + COUNT_BITS'(1);
				if (phase_q == PhPayload) begin
					ev_pay = 1'b1;
					plen_n = plen_q + 62'd1;
					if (flags_q[FlLen] && plen_n == accum_q) begin
						ev_close = 1'b1;
					end else if (last) begin
						ev_close  = 1'b1;
						close_err = flags_q[FlLen];
					end
				end else begin
					if (left_q == 3'd0) begin
						acc_n  = 62'(data.data_byte[5:0]);
						left_n = 3'((4'd1 << data.data_byte[7:6]) - 4'd1);
					end else begin
						acc_n  = {accum_q[53:0], data.data_byte};
						left_n = left_q - 3'd1;
					end
					if (left_n != 3'd0) begin
						if (last) begin
							ev_close  = 1'b1;
							close_err = 1'b1;
						end
					end else begin
						unique case (phase_q)
							PhType: begin
								if (acc_n >= 62'(FtStreamLo) && acc_n <= 62'(FtStreamHi)) begin
									kind_n  = FkStream;
									flags_n = acc_n[2:0];
									ph_n    = PhSid;
								end else if (acc_n == 62'(FtMaxData)) begin
									kind_n = FkMaxData;
									ph_n   = PhFval;
								end else if (acc_n == 62'(FtMaxStreamData)) begin
									kind_n = FkMaxStreamData;
									ph_n   = PhFsid;
								end else begin
									ev_close  = 1'b1;
									close_err = 1'b1;
									err_code  = ErrType;
								end
							end
							PhSid: begin
								ident_n = acc_n;
								ph_n    = flags_q[FlOff] ? PhOff :
								          (flags_q[FlLen] ? PhLen : PhPayload);
							end
							PhOff: begin
								value_n = acc_n;
								ph_n    = flags_q[FlLen] ? PhLen : PhPayload;
							end
							PhLen: begin
								if (len_sum > CountMaxWide) begin
									ev_close  = 1'b1;
									close_err = 1'b1;
									err_code  = ErrCount;
								end else if (acc_n == 62'd0) begin
									ev_close = 1'b1;
								end else begin
									ph_n = PhPayload;
								end
							end
							PhFsid: begin
								ident_n = acc_n;
								ph_n    = PhFval;
							end
							PhFval: begin
								value_n  = acc_n;
								ev_close = 1'b1;
							end
							default: begin
							end
						endcase
						if (!ev_close && last) begin
							ev_close  = 1'b1;
							close_err = !(ph_n == PhPayload && !flags_n[FlLen]);
						end
					end
				end
			end
		end
	end

	// event output
	always_comb begin
		push        = accept && (ev_pay || ev_close);
		ev.pay      = ev_pay;
		ev.pay_byte = data.data_byte;
		ev.close    = ev_close;
		ev.is_err   = close_err;
		ev.err_code = err_code;
		ev.kind     = kind_n;
		ev.ident    = ident_n;
		ev.value    = value_n;
		ev.fin      = (kind_n == FkStream) ? flags_n[FlFin] : 1'b0;
		ev.plen     = (kind_n == FkStream) ? plen_n : '0;
		ev.bytes    = 16'(bc_n);
	end

	// next state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhType;
			accum_q <= '0;
			left_q  <= '0;
			flags_q <= '0;
			kind_q  <= FkStream;
			ident_q <= '0;
			value_q <= '0;
			plen_q  <= '0;
			bc_q    <= '0;
		end else if (accept) begin
			if ((phase_q == PhSkip || ev_close) && last) begin
				phase_q <= PhType;
				accum_q <= '0;
				left_q  <= '0;
				flags_q <= '0;
				kind_q  <= FkStream;
				ident_q <= '0;
				value_q <= '0;
				plen_q  <= '0;
				bc_q    <= '0;
			end else if (ev_close) begin
				phase_q <= PhSkip;
			end else if (phase_q != PhSkip) begin
				phase_q <= ph_n;
				accum_q <= acc_n;
				left_q  <= left_n;
				flags_q <= flags_n;
				kind_q  <= kind_n;
				ident_q <= ident_n;
				value_q <= value_n;
				plen_q  <= plen_n;
				bc_q    <= bc_n;
			end
		end
	end

	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PhSkip) |-> !push)
		else $error("item pushed while skipping the frame tail");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PhPayload && flags_q[FlLen]) |-> (plen_q < accum_q))
		else $error("payload count reached declared length without closing");

endmodule
`default_nettype wire

// File: src/qfhp_queue.sv
`default_nettype none
//------------------------------------------------------------------------------
// QUIC frame header parser - event queue
// Short FIFO between the parsing front end and the result emitter.
//------------------------------------------------------------------------------
module qfhp_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire qfhp_pkg::event_t push_ev,
	output      logic             full,
	output      logic             q_valid,
	output      qfhp_pkg::event_t q_ev,
	input  wire logic             pop
);
	import qfhp_pkg::*;

	event_t               mem_q [QDepth];
	logic [QPtrBits-1:0]  wr_q;
	logic [QPtrBits-1:0]  rd_q;
	logic [QCntBits-1:0]  count_q;

	assign full    = (count_q == QCntBits'(QDepth));
	assign q_valid = (count_q != '0);
	assign q_ev    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPtrBits'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPtrBits'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCntBits'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCntBits'(1);
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCntBits'(QDepth))
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

// File: src/qfhp_back.sv
`default_nettype none
//------------------------------------------------------------------------------
// QUIC frame header parser - result emitter
// Holds one event and sends its payload item and closing item in turn.
//------------------------------------------------------------------------------
module qfhp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire qfhp_pkg::event_t q_ev,
	output      logic             pop,
	qfhp_out_if.source            result
);
	import qfhp_pkg::*;

	event_t ev_q;
	logic   pay_q;
	logic   cls_q;
	logic   fire;
	logic   free_next;

	assign fire      = result.valid && result.ready;
	assign free_next = !(pay_q || cls_q) || (fire && !(pay_q && cls_q));
	assign pop       = q_valid && free_next;

	always_ff @(posedge clk) begin
		if (pop) begin
			ev_q <= q_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay_q <= 1'b0;
			cls_q <= 1'b0;
		end else if (pop) begin
			pay_q <= q_ev.pay;
			cls_q <= q_ev.close;
		end else if (fire) begin
			if (pay_q) begin
				pay_q <= 1'b0;
			end else begin
				cls_q <= 1'b0;
			end
		end
	end

	always_comb begin
		result.valid          = pay_q || cls_q;
		result.result_kind    = RkPayload;
		result.payload_byte   = '0;
		result.frame_kind     = FkStream;
		result.stream_ident   = '0;
		result.field_value    = '0;
		result.fin_flag       = 1'b0;
		result.payload_length = '0;
		result.bytes_consumed = '0;
		result.error_code     = ErrTrunc;
		result.run_end        = 1'b1;
		if (pay_q) begin
			result.payload_byte = ev_q.pay_byte;
			result.run_end      = !cls_q;
		end else if (ev_q.is_err) begin
			result.result_kind = RkError;
			result.error_code  = ev_q.err_code;
		end else begin
			result.result_kind    = RkComplete;
			result.frame_kind     = ev_q.kind;
			result.stream_ident   = ev_q.ident;
			result.field_value    = ev_q.value;
			result.fin_flag       = ev_q.fin;
			result.payload_length = ev_q.plen;
			result.bytes_consumed = ev_q.bytes;
		end
	end

	a_close_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && pay_q && cls_q) |=> (result.valid && cls_q && !pay_q))
		else $error("closing item lost after payload item");

endmodule
`default_nettype wire

// File: src/quic_frame_header_parser.sv
`default_nettype none
//------------------------------------------------------------------------------
// QUIC frame header parser
// Parses the first QUIC frame of a byte-serial buffer and emits payload and
// closing result items.
//------------------------------------------------------------------------------
// Takes one buffer byte per cycle on data and keeps that rate for as long as
// results are drained. Each byte is parsed in the front end in the cycle it
// is accepted and any event it gives enters a four-entry queue at that edge;
// the emitter loads the event from the queue into its own register once it
// is free, and the byte's first result is presented from that register.
// A byte that both carries the final payload byte and closes the frame gives
// two items, which the emitter sends in turn, payload first, while the queue
// keeps taking bytes; data.ready drops only when the queue is full. A frame
// byte beyond 2^COUNT_BITS - 1 closes the frame with a byte count error, and
// bytes_consumed gives the low 16 bits of the count. No clearing pass after
// reset.
//------------------------------------------------------------------------------
module quic_frame_header_parser #(
	parameter int COUNT_BITS = qfhp_pkg::CountBitsDef
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	qfhp_in_if.sink    data,
	qfhp_out_if.source result
);
	import qfhp_pkg::*;

	logic   push;
	event_t push_ev;
	logic   full;
	logic   q_valid;
	event_t q_ev;
	logic   pop;

	qfhp_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.data   (data),
		.push   (push),
		.ev     (push_ev),
		.full   (full)
	);

	qfhp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_ev (push_ev),
		.full    (full),
		.q_valid (q_valid),
		.q_ev    (q_ev),
		.pop     (pop)
	);

	qfhp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ev    (q_ev),
		.pop     (pop),
		.result  (result)
	);

endmodule
`default_nettype wire

// File: bench/qfhp_frame_checker.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// QUIC frame header parser - result checker
// Watches both channels. Each byte accepted on the byte channel runs through
// a parser model of its own, and the results it should cause are queued. Each
// item taken from the result channel is compared field by field with the
// oldest queued result. The mismatch count and the number of results still
// due go back to the testbench top.
//------------------------------------------------------------------------------
module qfhp_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	qfhp_in_if          data,
	qfhp_out_if         result,
	output int unsigned mismatches,
	output int unsigned results_due
);
	import qfhp_pkg::*;

	typedef struct {
		result_kind_t kind;
		logic [7:0]   pay;
		frame_kind_t  fkind;
		varint_t      ident;
		varint_t      value;
		logic         fin;
		varint_t      plen;
		logic [15:0]  nbytes;
		err_code_t    err;
		logic         run_end;
	} parse_result_t;

	localparam logic [63:0] CountMax = (64'd1 << CountBitsDef) - 64'd1;

	phase_t        phase;
	varint_t       accum;
	logic [2:0]    varint_left;
	logic [2:0]    flags;
	frame_kind_t   held_kind;
	varint_t       held_ident;
	varint_t       held_value;
	varint_t       delivered;
	logic [63:0]   frame_bytes;

	parse_result_t byte_out [2];
	int            byte_out_n;
	parse_result_t pending_results [$];
	int unsigned   errors = 0;

	function automatic void clear_frame_state();
		phase       = PhType;
		accum       = '0;
		varint_left = '0;
		flags       = '0;
		held_kind   = FkStream;
		held_ident  = '0;
		held_value  = '0;
		delivered   = '0;
		frame_bytes = '0;
	endfunction

	function automatic parse_result_t blank_result();
		parse_result_t r;
		r.kind    = RkPayload;
		r.pay     = '0;
		r.fkind   = FkStream;
		r.ident   = '0;
		r.value   = '0;
		r.fin     = 1'b0;
		r.plen    = '0;
		r.nbytes  = '0;
		r.err     = ErrTrunc;
		r.run_end = 1'b0;
		return r;
	endfunction

	function automatic void end_frame(logic last);
		if (last) begin
			clear_frame_state();
		end else begin
			phase = PhSkip;
		end
	endfunction

	function automatic void add_error(err_code_t code, logic last);
		parse_result_t r;
		r      = blank_result();
		r.kind = RkError;
		r.err  = code;
		byte_out[byte_out_n] = r;
		byte_out_n++;
		end_frame(last);
	endfunction

	function automatic void add_complete(logic last);
		parse_result_t r;
		r       = blank_result();
		r.kind  = RkComplete;
		r.fkind = held_kind;
		r.ident = held_ident;
		r.value = held_value;
		if (held_kind == FkStream) begin
			r.fin  = flags[FlFin];
			r.plen = delivered;
		end
		r.nbytes = frame_bytes[15:0];
		byte_out[byte_out_n] = r;
		byte_out_n++;
		end_frame(last);
	endfunction

	function automatic void parse_frame_byte(logic [7:0] b, logic last);
		parse_result_t r;
		byte_out_n = 0;
		if (phase == PhSkip) begin
			if (last) clear_frame_state();
			return;
		end
		if (frame_bytes + 64'd1 > CountMax) begin
			add_error(ErrCount, last);
			return;
		end
		frame_bytes++;

		if (phase == PhPayload) begin
			r     = blank_result();
			r.pay = b;
			byte_out[0] = r;
			byte_out_n  = 1;
			delivered++;
			if (flags[FlLen] && delivered == accum) begin
				add_complete(last);
			end else if (last && flags[FlLen]) begin
				add_error(ErrTrunc, 1'b1);
			end else if (last) begin
				add_complete(1'b1);
			end
			return;
		end

		if (varint_left == 3'd0) begin
			accum = varint_t'(b[5:0]);
			case (b[7:6])
				2'd0: varint_left = 3'd0;
				2'd1: varint_left = 3'd1;
				2'd2: varint_left = 3'd3;
				default: varint_left = 3'd7;
			endcase
		end else begin
			accum = {accum[53:0], b};
			varint_left--;
		end
		if (varint_left != 3'd0) begin
			if (last) add_error(ErrTrunc, 1'b1);
			return;
		end

		case (phase)
			PhType: begin
				if (accum >= FtStreamLo && accum <= FtStreamHi) begin
					held_kind = FkStream;
					flags     = accum[2:0];
					phase     = PhSid;
				end else if (accum == FtMaxData) begin
					held_kind = FkMaxData;
					phase     = PhFval;
				end else if (accum == FtMaxStreamData) begin
					held_kind = FkMaxStreamData;
					phase     = PhFsid;
				end else begin
					add_error(ErrType, last);
					return;
				end
			end
			PhSid: begin
				held_ident = accum;
				if (flags[FlOff]) begin
					phase = PhOff;
				end else if (flags[FlLen]) begin
					phase = PhLen;
				end else begin
					phase = PhPayload;
				end
			end
			PhOff: begin
				held_value = accum;
				if (flags[FlLen]) begin
					phase = PhLen;
				end else begin
					phase = PhPayload;
				end
			end
			PhLen: begin
				if ({2'b00, accum} + frame_bytes > CountMax) begin
					add_error(ErrCount, last);
					return;
				end
				if (accum == '0) begin
					add_complete(last);
					return;
				end
				phase = PhPayload;
			end
			PhFsid: begin
				held_ident = accum;
				phase      = PhFval;
			end
			default: begin
				held_value = accum;
				add_complete(last);
				return;
			end
		endcase

		if (last) begin
			if (phase == PhPayload && !flags[FlLen]) begin
				add_complete(1'b1);
			end else begin
				add_error(ErrTrunc, 1'b1);
			end
		end
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		parse_result_t want;
		if (!arst_n) begin
			clear_frame_state();
			pending_results.delete();
			results_due <= 0;
			mismatches  <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result item expected none, got kind 0x%0h",
						$time, result.result_kind);
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("result_kind", want.kind, result.result_kind);
					check_field("payload_byte", want.pay, result.payload_byte);
					check_field("frame_kind", want.fkind, result.frame_kind);
					check_field("stream_ident", want.ident, result.stream_ident);
					check_field("field_value", want.value, result.field_value);
					check_field("fin_flag", want.fin, result.fin_flag);
					check_field("payload_length", want.plen, result.payload_length);
					check_field("bytes_consumed", want.nbytes, result.bytes_consumed);
					check_field("error_code", want.err, result.error_code);
					check_field("run_end", want.run_end, result.run_end);
				end
			end
			if (data.valid && data.ready) begin
				parse_frame_byte(data.data_byte, data.last_byte);
				if (byte_out_n > 0) byte_out[byte_out_n - 1].run_end = 1'b1;
				for (int i = 0; i < byte_out_n; i++) pending_results.push_back(byte_out[i]);
			end
			results_due <= pending_results.size();
			mismatches  <= errors;
		end
	end

endmodule

// File: bench/quic_frame_header_parser_test.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// QUIC frame header parser - testbench
// Sends byte buffers to the parser: a short directed set, a long receiver
// hold-off, then random well-formed, broken and noise buffers, with random
// idle bursts on both channels. A checker beside the parser predicts and
// compares every result item.
//------------------------------------------------------------------------------
module quic_frame_header_parser_test;
	import qfhp_pkg::*;

	localparam logic [7:0] TypeStreamLen = FtStreamLo | (8'd1 << FlLen);
	localparam logic [7:0] TypeUnknown   = FtStreamLo - 8'd1;
	localparam logic [7:0] Varint2       = 8'h40;
	localparam logic [7:0] Varint8       = 8'hC0;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	bit          idle_on     = 1'b1;
	bit          long_hold   = 1'b0;
	int unsigned bytes_sent  = 0;
	int unsigned mismatches;
	int unsigned results_due;
	int unsigned random_start;
	logic [7:0]  frame_buf [$];

	qfhp_in_if  data_ch ();
	qfhp_out_if result_ch ();

	quic_frame_header_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.data   (data_ch),
		.result (result_ch)
	);

	qfhp_frame_checker frame_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.data        (data_ch),
		.result      (result_ch),
		.mismatches  (mismatches),
		.results_due (results_due)
	);

	always #5 clk = ~clk;

	initial begin
		#(20_000_000);
		$display("Simulation FAILED");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				result_ch.ready <= 1'b0;
				repeat (250) @(posedge clk);
				long_hold = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_buffer();
		for (int i = 0; i < frame_buf.size(); i++) begin
			if (idle_on && $urandom_range(0, 5) == 0) begin
				data_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			data_ch.valid     <= 1'b1;
			data_ch.data_byte <= frame_buf[i];
			data_ch.last_byte <= (i == frame_buf.size() - 1);
			@(posedge clk);
			while (!data_ch.ready) @(posedge clk);
			bytes_sent++;
		end
		frame_buf.delete();
	endtask

	task automatic wait_all_results();
		data_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
	endtask

	function automatic void put_varint(logic [61:0] v, int unsigned code);
		int          n;
		logic [63:0] w;
		logic [7:0]  b;
		n = 1 << code;
		w = {2'b00, v} & ((64'd1 << (8 * n - 2)) - 64'd1);
		for (int i = n - 1; i >= 0; i--) begin
			b = w[8 * i +: 8];
			if (i == n - 1) b[7:6] = code[1:0];
			frame_buf.push_back(b);
		end
	endfunction

	function automatic void put_rand_varint();
		logic [61:0] v;
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			default: v = 62'({$urandom, $urandom});
		endcase
		put_varint(v, $urandom_range(0, 3));
	endfunction

	// mostly minimal, sometimes a longer encoding of the frame type
	function automatic int unsigned type_size();
		if ($urandom_range(0, 3) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	function automatic void build_random_buffer();
		int unsigned sel;
		int unsigned plen;
		int unsigned cut;
		logic [2:0]  fl;
		logic [61:0] v;
		sel = $urandom_range(0, 99);
		if (sel < 72) begin
			case ($urandom_range(0, 2))
				0: begin
					fl = 3'($urandom_range(0, 7));
					put_varint(FtStreamLo | fl, type_size());
					put_rand_varint();
					if (fl[FlOff]) put_rand_varint();
					plen = $urandom_range(0, 12);
					if (fl[FlLen]) put_varint(plen, $urandom_range(0, 3));
					repeat (plen) frame_buf.push_back(8'($urandom));
				end
				1: begin
					put_varint(FtMaxData, type_size());
					put_rand_varint();
				end
				default: begin
					put_varint(FtMaxStreamData, type_size());
					put_rand_varint();
					put_rand_varint();
				end
			endcase
			repeat ($urandom_range(0, 3)) frame_buf.push_back(8'($urandom));
			if ($urandom_range(0, 9) == 0 && frame_buf.size() > 1) begin
				cut = $urandom_range(1, frame_buf.size() - 1);
				repeat (cut) void'(frame_buf.pop_back());
			end
		end else if (sel < 84) begin
			do begin
				case ($urandom_range(0, 2))
					0: v = 62'($urandom_range(0, 7));
					1: v = 62'($urandom_range(18, 63));
					default: v = 62'({$urandom, $urandom});
				endcase
			end while (v >= FtStreamLo && v <= FtMaxStreamData);
			if (v < 62'd64) begin
				put_varint(v, $urandom_range(0, 3));
			end else begin
				put_varint(v, 3);
			end
			repeat ($urandom_range(0, 4)) frame_buf.push_back(8'($urandom));
		end else if (sel < 92) begin
			// declared length beyond the byte bound
			put_varint(TypeStreamLen, type_size());
			put_rand_varint();
			if ($urandom_range(0, 1) != 0) begin
				v = 62'($urandom_range(65530, 70000));
				put_varint(v, $urandom_range(2, 3));
			end else begin
				v = 62'({$urandom, $urandom}) | (62'd1 << 20);
				put_varint(v, 3);
			end
			repeat ($urandom_range(0, 4)) frame_buf.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 8)) frame_buf.push_back(8'($urandom));
		end
	endfunction

	initial begin
		data_ch.valid     <= 1'b0;
		data_ch.data_byte <= '0;
		data_ch.last_byte <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		frame_buf = '{FtMaxData, 8'h3F};
		send_buffer();
		frame_buf = '{FtMaxStreamData, 8'h00, 8'h00};
		send_buffer();
		frame_buf = '{FtStreamHi, 8'h01, 8'h02, 8'h01, 8'hAA, 8'h55};
		send_buffer();
		frame_buf = '{FtStreamLo, 8'h05};
		send_buffer();
		frame_buf = '{TypeStreamLen, 8'h00, 8'h00};
		send_buffer();
		frame_buf = '{TypeUnknown};
		send_buffer();
		frame_buf = '{Varint2, FtMaxData, 8'h00};
		send_buffer();
		frame_buf = '{TypeStreamLen, 8'h01, 8'h03, 8'hBB};
		send_buffer();
		frame_buf = '{Varint8};
		send_buffer();

		// result side held off while payload keeps coming
		long_hold = 1'b1;
		frame_buf = '{TypeStreamLen, 8'h00, Varint2, 8'd64};
		repeat (64) frame_buf.push_back(8'($urandom));
		send_buffer();
		wait_all_results();

		random_start = bytes_sent;
		while (bytes_sent - random_start < 1300) begin
			if (bytes_sent - random_start > 1100) begin
				idle_on = 1'b0;
			end else begin
				idle_on = ($urandom_range(0, 4) != 0);
			end
			build_random_buffer();
			send_buffer();
			if ($urandom_range(0, 24) == 0) wait_all_results();
		end
		wait_all_results();
		repeat (20) @(posedge clk);

		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/qfhp_pkg.sv
src/qfhp_in_if.sv
src/qfhp_out_if.sv
src/qfhp_front.sv
src/qfhp_queue.sv
src/qfhp_back.sv
src/quic_frame_header_parser.sv
bench/qfhp_frame_checker.sv
bench/quic_frame_header_parser_test.sv
